// ===== rtl/anxb_pkg.sv =====
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter package
// Shared types, codes and constants of the start code parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anxb_pkg;

    localparam int LENGTH_BITS    = 20;
    localparam int LEN_FIELD_BITS = 20;
    localparam int CNT_SUM_BITS   = LENGTH_BITS + 1;
    localparam int CMP_BITS       = (LENGTH_BITS > LEN_FIELD_BITS) ? LENGTH_BITS
                                                                   : LEN_FIELD_BITS;
    localparam int MAX_RESULTS    = 5;
    localparam int RES_IDX_BITS   = 3;

    localparam logic [LENGTH_BITS-1:0]    COUNT_MAX     = {LENGTH_BITS{1'b1}};
    localparam logic [LEN_FIELD_BITS-1:0] LEN_FIELD_MAX = {LEN_FIELD_BITS{1'b1}};

    localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
    localparam logic [7:0] HDR_IDC_MASK       = 8'h60;
    localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;
    localparam logic [4:0] NAL_TYPE_SEI       = 5'd6;
    localparam logic [7:0] BYTE_ZERO          = 8'h00;
    localparam logic [7:0] BYTE_ONE           = 8'h01;
    localparam logic [2:0] PREFIX_SHORT       = 3'd3;
    localparam logic [2:0] PREFIX_LONG        = 3'd4;
    localparam logic [1:0] HOLD_FULL          = 2'd3;

    typedef enum logic [1:0] {
        MODE_AWAIT = 2'd0,
        MODE_SKIP  = 2'd1,
        MODE_UNIT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD    = 2'd0,
        KIND_SUMMARY    = 2'd1,
        KIND_SYNC_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        mode_t                  mode;
        logic [1:0]             hold_count;
        logic [LENGTH_BITS-1:0] count;
        logic [7:0]             header;
        logic [2:0]             prefix;
    } parse_state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                payload_byte;
        logic                      first_of_unit;
        logic [LEN_FIELD_BITS-1:0] unit_length;
        logic [2:0]                prefix_length;
        logic                      forbidden_zero;
        logic [1:0]                reference_idc;
        logic [4:0]                unit_type;
        logic                      length_saturated;
    } result_t;

    localparam parse_state_t PARSE_RESET = '{
        mode:       MODE_AWAIT,
        hold_count: 2'd0,
        count:      '0,
        header:     8'h00,
        prefix:     PREFIX_SHORT
    };

endpackage

`default_nettype wire

// ===== rtl/anxb_step.sv =====
// ----------------------------------------------------------------------------
// Annex B splitter step logic
// Computes the results of one stream byte and the parser state after it.
// ----------------------------------------------------------------------------
`default_nettype none

module anxb_step
    import anxb_pkg::*;
(
    input  parse_state_t                  state,
    input  logic [7:0]                    stream_byte,
    input  logic                          end_of_stream,
    input  logic                          skip_sei_payload,
    output parse_state_t                  state_next,
    output result_t                       results [MAX_RESULTS],
    output logic [RES_IDX_BITS-1:0]       result_count
);

    function automatic logic [LEN_FIELD_BITS-1:0] len_field(
        input logic [LENGTH_BITS-1:0] c
    );
        logic [CMP_BITS-1:0] w;
        begin
            w = CMP_BITS'(c);
            if (w > CMP_BITS'(LEN_FIELD_MAX))
                len_field = LEN_FIELD_MAX;
            else
                len_field = w[LEN_FIELD_BITS-1:0];
        end
    endfunction

    function automatic result_t summary(
        input logic [LENGTH_BITS-1:0] c,
        input logic [7:0]             hdr,
        input logic [2:0]             pfx
    );
        result_t r;
        begin
            r                  = '0;
            r.kind             = KIND_SUMMARY;
            r.unit_length      = len_field(c);
            r.prefix_length    = pfx;
            r.forbidden_zero   = (hdr & HDR_FORBIDDEN_MASK) != 8'h00;
            r.reference_idc    = 2'((hdr & HDR_IDC_MASK) >> 5);
            r.unit_type        = 5'(hdr & HDR_TYPE_MASK);
            r.length_saturated = (c == COUNT_MAX);
            summary = r;
        end
    endfunction

    parse_state_t                  s1;
    logic                          is_start;
    logic                          opened;
    logic                          err;
    logic                          sum_a;
    logic                          sum_b;
    logic                          last_is_b;
    logic [2:0]                    e1;
    logic [2:0]                    e2;
    logic [2:0]                    e_total;
    logic [CNT_SUM_BITS-1:0]       cnt_sum;
    logic [LENGTH_BITS-1:0]        cnt_e;
    logic [7:0]                    first_val;
    logic [7:0]                    hdr_e;
    logic                          suppress;
    logic [RES_IDX_BITS-1:0]       n_emit;
    logic [RES_IDX_BITS-1:0]       emit_start;
    logic [RES_IDX_BITS-1:0]       sum_a_pos;
    logic [RES_IDX_BITS-1:0]       sum_b_pos;
    logic [RES_IDX_BITS-1:0]       slot;
    logic [RES_IDX_BITS-1:0]       k;

    always_comb
    begin
        s1        = state;
        opened    = 1'b0;
        err       = 1'b0;
        sum_a     = 1'b0;
        last_is_b = 1'b0;
        e1        = 3'd0;
        is_start  = (stream_byte == BYTE_ONE) && (state.hold_count >= 2'd2);

        if (state.mode == MODE_UNIT)
        begin
            if (stream_byte == BYTE_ZERO)
            begin
                if (state.hold_count == HOLD_FULL)
                    e1 = 3'd1;
                else
                    s1.hold_count = state.hold_count + 2'd1;
            end
            else if (is_start)
            begin
                sum_a  = 1'b1;
                opened = 1'b1;
            end
            else
            begin
                e1            = {1'b0, state.hold_count} + 3'd1;
                last_is_b     = 1'b1;
                s1.hold_count = 2'd0;
            end
        end
        else if (state.mode == MODE_SKIP)
        begin
            if (stream_byte == BYTE_ZERO)
            begin
                if (state.hold_count != HOLD_FULL)
                    s1.hold_count = state.hold_count + 2'd1;
            end
            else if (is_start)
                opened = 1'b1;
            else
                s1.hold_count = 2'd0;
        end
        else
        begin
            if (stream_byte == BYTE_ZERO)
            begin
                if (state.hold_count != HOLD_FULL)
                    s1.hold_count = state.hold_count + 2'd1;
                else
                begin
                    err           = 1'b1;
                    s1.mode       = MODE_SKIP;
                    s1.hold_count = HOLD_FULL;
                end
            end
            else if (is_start)
                opened = 1'b1;
            else
            begin
                err           = 1'b1;
                s1.mode       = MODE_SKIP;
                s1.hold_count = 2'd0;
            end
        end

        if (opened)
        begin
            s1.mode       = MODE_UNIT;
            s1.count      = '0;
            s1.header     = 8'h00;
            s1.prefix     = (state.hold_count == HOLD_FULL) ? PREFIX_LONG : PREFIX_SHORT;
            s1.hold_count = 2'd0;
        end

        sum_b   = end_of_stream && (s1.mode == MODE_UNIT);
        e2      = sum_b ? {1'b0, s1.hold_count} : 3'd0;
        e_total = e1 + e2;

        cnt_sum = {1'b0, s1.count} + CNT_SUM_BITS'(e_total);
        if (cnt_sum > CNT_SUM_BITS'(COUNT_MAX))
            cnt_e = COUNT_MAX;
        else
            cnt_e = cnt_sum[LENGTH_BITS-1:0];

        first_val = (last_is_b && (e_total == 3'd1)) ? stream_byte : BYTE_ZERO;
        hdr_e     = ((s1.count == '0) && (e_total != 3'd0)) ? first_val : s1.header;
        suppress  = skip_sei_payload && (hdr_e[4:0] == NAL_TYPE_SEI);
        n_emit    = suppress ? '0 : RES_IDX_BITS'(e_total);

        emit_start   = {{(RES_IDX_BITS-1){1'b0}}, err};
        sum_a_pos    = emit_start + n_emit;
        sum_b_pos    = sum_a_pos + {{(RES_IDX_BITS-1){1'b0}}, sum_a};
        result_count = sum_b_pos + {{(RES_IDX_BITS-1){1'b0}}, sum_b};

        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            slot       = RES_IDX_BITS'(j);
            k          = slot - emit_start;
            results[j] = '0;
            if (err && (slot == '0))
                results[j].kind = KIND_SYNC_ERROR;
            else if ((slot >= emit_start) && (slot < sum_a_pos))
            begin
                results[j].kind          = KIND_PAYLOAD;
                results[j].payload_byte  =
                    (last_is_b && (k == RES_IDX_BITS'(e_total - 3'd1))) ? stream_byte
                                                                         : BYTE_ZERO;
                results[j].first_of_unit = (s1.count == '0) && (k == '0);
            end
            else if (sum_a && (slot == sum_a_pos))
                results[j] = summary(state.count, state.header, state.prefix);
            else if (sum_b && (slot == sum_b_pos))
                results[j] = summary(cnt_e, hdr_e, s1.prefix);
        end

        if (end_of_stream)
            state_next = PARSE_RESET;
        else
        begin
            state_next        = s1;
            state_next.count  = cnt_e;
            state_next.header = hdr_e;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/annexb_nal_unit_splitter.sv =====
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Splits an H.264 Annex B byte stream into NAL unit bytes and unit summaries.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per transfer, with end_of_stream on the last
// byte. Output channel: one result per transfer (payload byte, unit summary or
// sync error); last_of_run marks the last result caused by one input byte.
// A transferred byte waits in the input register until the result bank is
// free; it is then parsed and its whole run of results (zero to five) is
// loaded into the result bank, and the first result is offered from then on.
// The bank drains one result per cycle while the receiver does not stall.
// Throughput is one byte per cycle while each byte causes at most one result
// and the receiver does not stall; a byte that causes more results holds the
// result bank until its last result transfers.
// A one-entry input register lets the next byte transfer while results still
// wait in the bank. When the receiver stalls, the current result holds and the
// input side stalls once the input register is full.
// Reset puts the parser in the awaiting-first-start-code mode with an empty
// bank and sets skip_sei_payload. cfg_wr_data is written to skip_sei_payload
// at any edge with cfg_wr_en high; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_unit_splitter
    import anxb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                stream_byte,
    input  logic                      end_of_stream,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                result_kind,
    output logic [7:0]                payload_byte,
    output logic                      first_of_unit,
    output logic [LEN_FIELD_BITS-1:0] unit_length,
    output logic [2:0]                prefix_length,
    output logic                      forbidden_zero,
    output logic [1:0]                reference_idc,
    output logic [4:0]                unit_type,
    output logic                      length_saturated,
    output logic                      last_of_run
);

    logic                    skip_sei_reg;
    logic                    in_full_reg;
    logic [7:0]              byte_reg;
    logic                    eos_reg;
    parse_state_t            state_reg;
    parse_state_t            state_next;
    result_t                 bank_reg [MAX_RESULTS];
    result_t                 bank_next [MAX_RESULTS];
    logic [RES_IDX_BITS-1:0] total_reg;
    logic [RES_IDX_BITS-1:0] total_next;
    logic [RES_IDX_BITS-1:0] rd_reg;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    last_res;
    logic                    bank_free;
    logic                    load;
    result_t                 cur;

    anxb_step u_step (
        .state            (state_reg),
        .stream_byte      (byte_reg),
        .end_of_stream    (eos_reg),
        .skip_sei_payload (skip_sei_reg),
        .state_next       (state_next),
        .results          (bank_next),
        .result_count     (total_next)
    );

    assign out_valid = (total_reg != '0);
    assign last_res  = (rd_reg == total_reg - RES_IDX_BITS'(1));
    assign out_xfer  = out_valid && !out_stall;
    assign bank_free = (total_reg == '0) || (out_xfer && last_res);
    assign load      = in_full_reg && bank_free;
    assign in_stall  = in_full_reg && !bank_free;
    assign in_xfer   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_sei_reg <= 1'b1;
        else if (cfg_wr_en)
            skip_sei_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_xfer)
            in_full_reg <= 1'b1;
        else if (load)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= stream_byte;
            eos_reg  <= end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PARSE_RESET;
        else if (load)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            rd_reg    <= '0;
        end
        else if (load)
        begin
            total_reg <= total_next;
            rd_reg    <= '0;
        end
        else if (out_xfer)
        begin
            if (last_res)
            begin
                total_reg <= '0;
                rd_reg    <= '0;
            end
            else
                rd_reg <= rd_reg + RES_IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bank_reg <= bank_next;
    end

    assign cur              = bank_reg[rd_reg];
    assign result_kind      = cur.kind;
    assign payload_byte     = cur.payload_byte;
    assign first_of_unit    = cur.first_of_unit;
    assign unit_length      = cur.unit_length;
    assign prefix_length    = cur.prefix_length;
    assign forbidden_zero   = cur.forbidden_zero;
    assign reference_idc    = cur.reference_idc;
    assign unit_type        = cur.unit_type;
    assign length_saturated = cur.length_saturated;
    assign last_of_run      = last_res;

endmodule

`default_nettype wire

// ===== rtl/anxb_checker.sv =====
// ----------------------------------------------------------------------------
// Annex B splitter port checker
// Checks result ordering and field consistency on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module anxb_checker
    import anxb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [1:0]                result_kind,
    input  logic [7:0]                payload_byte,
    input  logic                      first_of_unit,
    input  logic [LEN_FIELD_BITS-1:0] unit_length,
    input  logic [2:0]                prefix_length,
    input  logic                      last_of_run
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(unit_length) && $stable(last_of_run))
        else $error("stalled result changed");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("run of results broken before its last transfer");

    a_summary_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_SUMMARY) |->
            (prefix_length == PREFIX_SHORT) || (prefix_length == PREFIX_LONG))
        else $error("summary with bad prefix length");

    a_first_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_of_unit |-> (result_kind == KIND_PAYLOAD))
        else $error("first_of_unit on a non-payload result");

endmodule

bind annexb_nal_unit_splitter anxb_checker u_anxb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .first_of_unit (first_of_unit),
    .unit_length   (unit_length),
    .prefix_length (prefix_length),
    .last_of_run   (last_of_run)
);

`default_nettype wire
